// ===== src/hts_pkg.sv =====
// Package for the heap timer scheduler: command and status codes, field widths.
`timescale 1ns / 1ps
package hts_pkg;

  localparam int unsigned TimeW     = 63;
  localparam int unsigned IdW       = 32;
  localparam int unsigned OrderW    = 64;
  localparam int unsigned HeapDepth = 16;
  localparam int unsigned MaxFires  = 16;

  typedef enum logic [1:0] {
    CMD_ONESHOT  = 2'd0,
    CMD_PERIODIC = 2'd1,
    CMD_CANCEL   = 2'd2,
    CMD_PROCESS  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0]  deadline;
    logic [TimeW-1:0]  period;
    logic [IdW-1:0]    ident;
    logic [OrderW-1:0] order;
  } entry_t;

  // a before b: earlier deadline, ties by insertion order
  function automatic logic earlier(input entry_t a, input entry_t b);
    logic r;
    if (a.deadline != b.deadline) r = a.deadline < b.deadline;
    else r = a.order < b.order;
    return r;
  endfunction

endpackage

// ===== src/heap_timer_scheduler_unit.sv =====
// Heap timer scheduler top level: heap store, sequencer and result register.
`timescale 1ns / 1ps
// Timer queue held as a binary min-heap of HEAP_DEPTH entries in registers, walked by one
// sequencer with a single shared entry compare. The input is ready only while the
// sequencer idles. An arm command runs a check, one compare per heap level on the way up
// and the alarm step. A cancel runs a check, a linear id search over the queued entries,
// a sift-down of two compares per level, a sift-up and the alarm step. A process command
// spends per fired timer a pop step, a step that hands the previous fired word (if one
// waits) to the output register, a sift-down and a requeue check, plus a sift-up for a
// periodic entry that still fits; then a final due check and the alarm step. Results
// leave through a one-word output register; a process command emits one word per fired
// timer, the last word flagged by m_axis_tlast and carrying the alarm fields. A receiver
// that holds m_axis_tready low stalls the sequencer whenever a word has to leave.
module heap_timer_scheduler_unit #(
  parameter int unsigned HEAP_DEPTH = hts_pkg::HeapDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: cmd[1:0], now[64:2], delay[127:65], cancel_id[159:128]
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[1:0], new_id[33:2], fired_valid[34], fired_id[66:35],
  //        alarm_write[67], alarm_time[130:68]
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import hts_pkg::*;

  localparam int unsigned IdxW  = $clog2(HEAP_DEPTH);
  localparam int unsigned CntW  = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned ChW   = IdxW + 2;
  localparam int unsigned FireW = $clog2(MaxFires + 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CHECK   = 9'b000000010,
    S_UP      = 9'b000000100,
    S_SEARCH  = 9'b000001000,
    S_DOWN_L  = 9'b000010000,
    S_DOWN_R  = 9'b000100000,
    S_POP     = 9'b001000000,
    S_REQUEUE = 9'b010000000,
    S_ALARM   = 9'b100000000
  } state_e;

  state_e state_q;

  entry_t heap_q [HEAP_DEPTH];

  logic [CntW-1:0]   occ_q;
  logic [IdW-1:0]    next_id_q;
  logic [OrderW-1:0] order_q;
  logic              alarm_set_q;
  logic [TimeW-1:0]  alarm_last_q;

  cmd_e              cmd_q;
  logic [TimeW-1:0]  now_q, delay_q;
  logic [IdW-1:0]    tid_q;

  logic [IdxW-1:0]   idx_q, min_q, found_q;
  logic              up_after_q;   // cancel: sift up after sift down
  logic [FireW-1:0]  fires_q;
  logic              pend_q;       // a fired word waits for emission
  logic [IdW-1:0]    pend_id_q;
  status_e           st_q;
  logic [IdW-1:0]    nid_q;

  logic              ovalid_q, olast_q;
  logic [135:0]      odata_q;

  // shared compare operands
  entry_t cmp_a, cmp_b;
  logic   cmp_lt;
  assign cmp_lt = earlier(cmp_a, cmp_b);

  logic [IdxW-1:0] par_idx, l_idx, r_idx, last_idx, occ_idx, down_pick;
  logic [ChW-1:0]  l_w, r_w, occ_w;
  assign par_idx  = (idx_q - IdxW'(1)) >> 1;
  assign l_w      = {1'b0, idx_q, 1'b1};
  assign r_w      = l_w + ChW'(1);
  assign occ_w    = ChW'(occ_q);
  assign l_idx    = l_w[IdxW-1:0];
  assign r_idx    = r_w[IdxW-1:0];
  assign last_idx = IdxW'(occ_q - CntW'(1));
  assign occ_idx  = IdxW'(occ_q);

  logic [TimeW:0] sum_w;
  assign sum_w = {1'b0, now_q} + {1'b0, delay_q};

  always_comb begin
    cmp_a = heap_q[idx_q];
    cmp_b = heap_q[par_idx];
    case (state_q)
      S_DOWN_L: begin
        cmp_a = heap_q[l_idx];
        cmp_b = heap_q[idx_q];
      end
      S_DOWN_R: begin
        cmp_a = heap_q[r_idx];
        cmp_b = heap_q[min_q];
      end
      default: ;
    endcase
  end

  logic arm_bad, arm_full, id_hit, due, up_swap, requeue_ok, out_free;
  assign arm_bad    = (cmd_q == CMD_PERIODIC && delay_q == '0) || sum_w[TimeW];
  assign arm_full   = occ_q >= CntW'(HEAP_DEPTH);
  assign id_hit     = heap_q[idx_q].ident == tid_q;
  assign due        = occ_q != '0 && heap_q[0].deadline <= now_q &&
                      fires_q != FireW'(MaxFires);
  assign up_swap    = idx_q != '0 && cmp_lt;
  assign down_pick  = (r_w < occ_w && cmp_lt) ? r_idx : min_q;
  assign requeue_ok = delay_q != '0 && !sum_w[TimeW];
  assign out_free   = !ovalid_q || m_axis_tready;

  // cancel and process ignore the previous alarm, so with status OK they always rewrite it for a non-empty heap
  logic alarm_fresh, alarm_wr;
  assign alarm_fresh = cmd_q == CMD_CANCEL || cmd_q == CMD_PROCESS;
  assign alarm_wr    = st_q == ST_OK && occ_q != '0 &&
                       (alarm_fresh || !alarm_set_q || heap_q[0].deadline < alarm_last_q);

  entry_t new_ent;
  assign new_ent = '{deadline: sum_w[TimeW-1:0],
                     period: (cmd_q == CMD_ONESHOT) ? '0 : delay_q,
                     ident: (cmd_q == CMD_PROCESS) ? pend_id_q : next_id_q,
                     order: order_q};

  logic         emit_mid, emit_fin;
  logic [135:0] mid_word, fin_word;
  assign emit_mid = state_q == S_POP && due && pend_q && out_free;
  assign emit_fin = state_q == S_ALARM && out_free;
  assign mid_word = {5'd0, {TimeW{1'b0}}, 1'b0, pend_id_q, 1'b1, {IdW{1'b0}}, ST_OK};
  assign fin_word = {5'd0, alarm_wr ? heap_q[0].deadline : {TimeW{1'b0}}, alarm_wr,
                     pend_q ? pend_id_q : {IdW{1'b0}}, pend_q, nid_q, st_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CHECK: begin
        if (cmd_q != CMD_CANCEL && cmd_q != CMD_PROCESS && !arm_bad && !arm_full) begin
          heap_q[occ_idx] <= new_ent;
        end
      end
      S_UP: begin
        if (up_swap) begin
          heap_q[idx_q]   <= heap_q[par_idx];
          heap_q[par_idx] <= heap_q[idx_q];
        end
      end
      S_SEARCH: begin
        if (id_hit && idx_q != last_idx) heap_q[idx_q] <= heap_q[last_idx];
      end
      S_DOWN_R: begin
        if (down_pick != idx_q) begin
          heap_q[idx_q]     <= heap_q[down_pick];
          heap_q[down_pick] <= heap_q[idx_q];
        end
      end
      S_POP: begin
        if (due && !pend_q) heap_q[0] <= heap_q[last_idx];
      end
      S_REQUEUE: begin
        if (requeue_ok) heap_q[occ_idx] <= new_ent;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      occ_q        <= '0;
      next_id_q    <= IdW'(1);
      order_q      <= '0;
      alarm_set_q  <= 1'b0;
      alarm_last_q <= '0;
      cmd_q        <= CMD_ONESHOT;
      now_q        <= '0;
      delay_q      <= '0;
      tid_q        <= '0;
      idx_q        <= '0;
      min_q        <= '0;
      found_q      <= '0;
      up_after_q   <= 1'b0;
      fires_q      <= '0;
      pend_q       <= 1'b0;
      pend_id_q    <= '0;
      st_q         <= ST_OK;
      nid_q        <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q   <= cmd_e'(s_axis_tdata[1:0]);
            now_q   <= s_axis_tdata[64:2];
            delay_q <= s_axis_tdata[127:65];
            tid_q   <= s_axis_tdata[159:128];
            fires_q <= '0;
            pend_q  <= 1'b0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          up_after_q <= 1'b0;
          case (cmd_q)
            CMD_CANCEL: begin
              idx_q <= '0;
              nid_q <= '0;
              if (tid_q == '0) begin
                st_q    <= ST_INVALID;
                state_q <= S_ALARM;
              end else if (occ_q == '0) begin
                st_q    <= ST_NOTFOUND;
                state_q <= S_ALARM;
              end else begin
                st_q    <= ST_OK;
                state_q <= S_SEARCH;
              end
            end
            CMD_PROCESS: begin
              idx_q   <= '0;
              nid_q   <= '0;
              st_q    <= ST_OK;
              state_q <= S_POP;
            end
            default: begin
              if (arm_bad) begin
                idx_q   <= '0;
                nid_q   <= '0;
                st_q    <= ST_INVALID;
                state_q <= S_ALARM;
              end else if (arm_full) begin
                idx_q   <= '0;
                nid_q   <= '0;
                st_q    <= ST_FULL;
                state_q <= S_ALARM;
              end else begin
                idx_q     <= occ_idx;
                occ_q     <= occ_q + CntW'(1);
                order_q   <= order_q + OrderW'(1);
                // skip id zero on wrap
                next_id_q <= (next_id_q == {IdW{1'b1}}) ? IdW'(1) : next_id_q + IdW'(1);
                nid_q     <= next_id_q;
                st_q      <= ST_OK;
                state_q   <= S_UP;
              end
            end
          endcase
        end
        S_UP: begin
          if (up_swap) begin
            idx_q <= par_idx;
          end else if (cmd_q == CMD_PROCESS) begin
            state_q <= S_POP;
          end else begin
            state_q <= S_ALARM;
          end
        end
        S_SEARCH: begin
          if (id_hit) begin
            occ_q <= occ_q - CntW'(1);
            if (idx_q != last_idx) begin
              found_q    <= idx_q;
              up_after_q <= 1'b1;
              state_q    <= S_DOWN_L;
            end else begin
              state_q <= S_ALARM;
            end
          end else if (idx_q == last_idx) begin
            st_q    <= ST_NOTFOUND;
            state_q <= S_ALARM;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        S_DOWN_L: begin
          min_q   <= (l_w < occ_w && cmp_lt) ? l_idx : idx_q;
          state_q <= S_DOWN_R;
        end
        S_DOWN_R: begin
          if (down_pick != idx_q) begin
            idx_q   <= down_pick;
            state_q <= S_DOWN_L;
          end else if (up_after_q) begin
            // sift up from the slot the cancelled entry left
            up_after_q <= 1'b0;
            idx_q      <= found_q;
            state_q    <= S_UP;
          end else if (cmd_q == CMD_PROCESS) begin
            state_q <= S_REQUEUE;
          end else begin
            state_q <= S_ALARM;
          end
        end
        S_POP: begin
          if (due) begin
            if (pend_q) begin
              // hand the previous fired word out before popping the next one
              if (out_free) pend_q <= 1'b0;
            end else begin
              pend_q    <= 1'b1;
              pend_id_q <= heap_q[0].ident;
              delay_q   <= heap_q[0].period;
              fires_q   <= fires_q + FireW'(1);
              occ_q     <= occ_q - CntW'(1);
              idx_q     <= '0;
              state_q   <= S_DOWN_L;
            end
          end else begin
            state_q <= S_ALARM;
          end
        end
        S_REQUEUE: begin
          if (requeue_ok) begin
            idx_q   <= occ_idx;
            occ_q   <= occ_q + CntW'(1);
            order_q <= order_q + OrderW'(1);
            state_q <= S_UP;
          end else begin
            state_q <= S_POP;
          end
        end
        S_ALARM: begin
          if (out_free) begin
            if (alarm_wr) begin
              alarm_set_q  <= 1'b1;
              alarm_last_q <= heap_q[0].deadline;
            end else if (st_q == ST_OK && occ_q == '0) begin
              alarm_set_q <= 1'b0;
            end
            pend_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
      odata_q  <= '0;
    end else if (emit_mid || emit_fin) begin
      ovalid_q <= 1'b1;
      olast_q  <= emit_fin;
      odata_q  <= emit_fin ? fin_word : mid_word;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

endmodule

// ===== sim/heap_timer_scheduler_unit_tb.sv =====
// Testbench for the heap timer scheduler: predicted timer queue checked word by word.
`timescale 1ns / 1ps
module heap_timer_scheduler_unit_tb;
  import hts_pkg::*;

  localparam int unsigned Depth = 16;
  localparam logic [62:0] TMax = {63{1'b1}};
  localparam logic [63:0] NoAlarm = {64{1'b1}};
  localparam int unsigned QuietLimit = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] new_id;
    logic        fired_valid;
    logic [31:0] fired_id;
    logic        alarm_write;
    logic [62:0] alarm_time;
    logic        last;
  } word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tlast;

  heap_timer_scheduler_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted timer queue
  entry_t      heap_q [Depth];
  int unsigned heap_cnt;
  logic [31:0] id_next;
  logic [63:0] seq_next;
  logic [63:0] alarm_at;

  word_t       expected_words[$];
  int          mismatches = 0;
  int          quiet = 0;
  bit          hold_off = 1'b0;
  logic [31:0] ids_seen[$];
  logic [62:0] clock_ns;

  function automatic bit before_slot(int unsigned a, int unsigned b);
    if (heap_q[a].deadline != heap_q[b].deadline) return heap_q[a].deadline < heap_q[b].deadline;
    return heap_q[a].order < heap_q[b].order;
  endfunction

  function automatic void swap_slot(int unsigned a, int unsigned b);
    entry_t t;
    t = heap_q[a]; heap_q[a] = heap_q[b]; heap_q[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!before_slot(i, p)) break;
      swap_slot(i, p);
      i = p;
    end
  endfunction

  function automatic void bubble_down(int unsigned i);
    int unsigned l, r, m;
    forever begin
      l = 2 * i + 1; r = 2 * i + 2; m = i;
      if (l < heap_cnt && before_slot(l, m)) m = l;
      if (r < heap_cnt && before_slot(r, m)) m = r;
      if (m == i) break;
      swap_slot(i, m);
      i = m;
    end
  endfunction

  function automatic void enqueue(logic [62:0] dl, logic [62:0] per, logic [31:0] id);
    heap_q[heap_cnt] = '{deadline: dl, period: per, ident: id, order: seq_next};
    seq_next++;
    heap_cnt++;
    bubble_up(heap_cnt - 1);
  endfunction

  function automatic bit rewrite_alarm(output logic [62:0] t);
    t = '0;
    if (heap_cnt == 0) begin
      alarm_at = NoAlarm;
      return 1'b0;
    end
    if (alarm_at == NoAlarm || {1'b0, heap_q[0].deadline} < alarm_at) begin
      alarm_at = {1'b0, heap_q[0].deadline};
      t = heap_q[0].deadline;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic word_t status_word(status_e st);
    return '{status: st, new_id: '0, fired_valid: 1'b0, fired_id: '0,
             alarm_write: 1'b0, alarm_time: '0, last: 1'b1};
  endfunction

  // work out the words one command yields and update the predicted queue
  function automatic void predict_command(cmd_e cmd, logic [62:0] now, logic [62:0] dly,
                                          logic [31:0] tid);
    word_t w;
    word_t fired[$];
    logic [62:0] t;
    bit aw;
    logic [31:0] id;
    logic [62:0] per;
    int unsigned found;
    int unsigned n;
    case (cmd)
      CMD_ONESHOT, CMD_PERIODIC: begin
        if ((cmd == CMD_PERIODIC && dly == 0) || dly > TMax - now) begin
          expected_words.push_back(status_word(ST_INVALID));
        end else if (heap_cnt >= Depth) begin
          expected_words.push_back(status_word(ST_FULL));
        end else begin
          id = id_next;
          id_next++;
          if (id_next == 0) id_next = 1;
          enqueue(now + dly, cmd == CMD_PERIODIC ? dly : '0, id);
          ids_seen.push_back(id);
          aw = rewrite_alarm(t);
          w = status_word(ST_OK);
          w.new_id = id; w.alarm_write = aw; w.alarm_time = t;
          expected_words.push_back(w);
        end
      end
      CMD_CANCEL: begin
        if (tid == 0) begin
          expected_words.push_back(status_word(ST_INVALID));
        end else begin
          found = Depth;
          for (int unsigned i = 0; i < heap_cnt; i++)
            if (found == Depth && heap_q[i].ident == tid) found = i;
          if (found == Depth) begin
            expected_words.push_back(status_word(ST_NOTFOUND));
          end else begin
            heap_cnt--;
            if (found < heap_cnt) begin
              heap_q[found] = heap_q[heap_cnt];
              bubble_down(found);
              bubble_up(found);
            end
            alarm_at = NoAlarm;
            aw = rewrite_alarm(t);
            w = status_word(ST_OK);
            w.alarm_write = aw; w.alarm_time = t;
            expected_words.push_back(w);
          end
        end
      end
      default: begin
        while (heap_cnt > 0 && heap_q[0].deadline <= now && fired.size() < MaxFires) begin
          per = heap_q[0].period;
          id = heap_q[0].ident;
          heap_cnt--;
          if (heap_cnt > 0) begin
            heap_q[0] = heap_q[heap_cnt];
            bubble_down(0);
          end
          w = status_word(ST_OK);
          w.fired_valid = 1'b1; w.fired_id = id; w.last = 1'b0;
          fired.push_back(w);
          if (per != 0 && per <= TMax - now) enqueue(now + per, per, id);
        end
        alarm_at = NoAlarm;
        aw = rewrite_alarm(t);
        if (fired.size() == 0) fired.push_back(status_word(ST_OK));
        n = fired.size() - 1;
        fired[n].alarm_write = aw; fired[n].alarm_time = t; fired[n].last = 1'b1;
        foreach (fired[k]) expected_words.push_back(fired[k]);
      end
    endcase
  endfunction

  task automatic send_command(cmd_e cmd, logic [62:0] now, logic [62:0] dly, logic [31:0] tid);
    int gap;
    gap = $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= {tid, dly, now, cmd};
    s_axis_tvalid <= 1'b1;
    predict_command(cmd, now, dly, tid);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_id();
    if (ids_seen.size() == 0 || $urandom_range(0, 5) == 0) return $urandom();
    return ids_seen[$urandom_range(0, ids_seen.size() - 1)];
  endfunction

  // result checker
  always @(posedge clk_i) begin
    word_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status      = m_axis_tdata[1:0];
      got.new_id      = m_axis_tdata[33:2];
      got.fired_valid = m_axis_tdata[34];
      got.fired_id    = m_axis_tdata[66:35];
      got.alarm_write = m_axis_tdata[67];
      got.alarm_time  = m_axis_tdata[130:68];
      got.last        = m_axis_tlast;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected st=%0d id=%0d fv=%0d fid=%0d aw=%0d at=%0d last=%0d",
                     want.status, want.new_id, want.fired_valid, want.fired_id,
                     want.alarm_write, want.alarm_time, want.last);
            $display("          got      st=%0d id=%0d fv=%0d fid=%0d aw=%0d at=%0d last=%0d",
                     got.status, got.new_id, got.fired_valid, got.fired_id,
                     got.alarm_write, got.alarm_time, got.last);
          end
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int gap;
    @(negedge clk_i);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  // watchdog: cycles with no word accepted on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    send_command(CMD_PROCESS, 63'd0, 63'd0, 32'd0);
    send_command(CMD_PERIODIC, 63'd10, 63'd0, 32'd0);
    send_command(CMD_ONESHOT, TMax, 63'd1, 32'd0);
    send_command(CMD_ONESHOT, 63'd1, TMax, 32'd0);
    send_command(CMD_ONESHOT, TMax, 63'd0, 32'd0);
    send_command(CMD_ONESHOT, 63'd0, 63'd0, 32'd0);
    send_command(CMD_PERIODIC, 63'd0, 63'd5, 32'd0);
    send_command(CMD_PERIODIC, 63'd0, TMax - 63'd2, 32'd0);
    send_command(CMD_ONESHOT, 63'd0, 63'd5, 32'd0);
    send_command(CMD_CANCEL, 63'd0, 63'd0, 32'd0);
    send_command(CMD_CANCEL, 63'd0, 63'd0, 32'hFFFF_FFFF);
    send_command(CMD_CANCEL, 63'd0, 63'd0, 32'd4);
    send_command(CMD_PROCESS, 63'd5, 63'd0, 32'd0);
    // periodic near the top of time: dropped on requeue
    send_command(CMD_PROCESS, TMax - 63'd1, 63'd0, 32'd0);
    // fill past capacity, all due together
    for (int i = 0; i < 18; i++) send_command(CMD_ONESHOT, 63'd100, 63'd0, 32'd0);
    send_command(CMD_PERIODIC, 63'd0, 63'd3, 32'd0);
    send_command(CMD_PROCESS, 63'd200, 63'd0, 32'd0);
    send_command(CMD_PROCESS, 63'd200, 63'd0, 32'd0);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++)
      send_command(cmd_e'($urandom_range(0, 2)), clock_ns, 63'($urandom_range(0, 50)),
                   pick_id());
  endtask

  task automatic test_random(int n);
    logic [62:0] dly;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) clock_ns = 63'({$urandom(), $urandom()} >> 1);
      else clock_ns = clock_ns + 63'($urandom_range(0, 40));
      if ($urandom_range(0, 9) == 0)
        dly = 63'({$urandom(), $urandom()} >> $urandom_range(1, 40));
      else dly = 63'($urandom_range(0, 60));
      if (pick < 35) send_command(CMD_ONESHOT, clock_ns, dly, 32'd0);
      else if (pick < 55) send_command(CMD_PERIODIC, clock_ns, dly, 32'd0);
      else if (pick < 70) send_command(CMD_CANCEL, clock_ns, 63'd0, pick_id());
      else send_command(CMD_PROCESS, clock_ns, dly, $urandom());
    end
  endtask

  initial begin
    heap_cnt = 0; id_next = 32'd1; seq_next = '0; alarm_at = NoAlarm; clock_ns = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random(170);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
